// File: sv/alr_pkg.sv
`default_nettype none

package alr_pkg;

   // Intensity scale: full weight is 200 steps.
   localparam logic [7:0]  WEIGHT_FULL  = 8'd200;
   // A neighbor pixel is drawn only above this error.
   localparam logic [7:0]  NEIGHBOR_MIN = 8'd2;
   // Dividend that turns a steep slope into its per-row increment.
   localparam logic [15:0] STEEP_RECIP  = 16'd40000;

   // floor(v / 25) == (v * RECIP_25) >> RECIP_SHIFT for v < 2^13.
   localparam logic [12:0] RECIP_25     = 13'd5243;
   localparam int          RECIP_SHIFT  = 17;

   localparam logic [7:0]  COLOR_RESET  = 8'd255;

   // Configuration register indexes.
   localparam int          CSR_IDX_BITS = 2;
   localparam logic [CSR_IDX_BITS-1:0] CSR_RED   = 2'd0;
   localparam logic [CSR_IDX_BITS-1:0] CSR_GREEN = 2'd1;
   localparam logic [CSR_IDX_BITS-1:0] CSR_BLUE  = 2'd2;

   // Minor-axis direction codes (two's complement step).
   localparam logic [1:0]  DIR_NONE = 2'd0;
   localparam logic [1:0]  DIR_UP   = 2'd1;
   localparam logic [1:0]  DIR_DOWN = 2'd3;

   typedef struct packed {
      logic end_of_item;
      logic line_done;
   } alr_flags_type;

   // floor(p / 200) for p = weight * color (p <= 51000).
   function automatic logic [7:0] scale200(input logic [15:0] p);
      logic [25:0] m;
      m = 26'(p[15:3]) * 26'(RECIP_25);
      return m[RECIP_SHIFT+7:RECIP_SHIFT];
   endfunction

endpackage

`default_nettype wire

// File: sv/alr_div.sv
`default_nettype none

// Restoring divider, one quotient bit per cycle.
module alr_div #(
   parameter int W = 18
) (
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         start,
   input  wire logic [W-1:0] dividend,
   input  wire logic [W-1:0] divisor,
   output logic              busy,
   output logic              done,
   output logic [W-1:0]      quotient
);

   localparam int CW = $clog2(W + 1);

   logic [W-1:0]  rem_ff, rem_in;
   logic [W-1:0]  dvd_ff, dvd_in;
   logic [W-1:0]  dsr_ff, dsr_in;
   logic [CW-1:0] cnt_ff, cnt_in;
   logic          busy_ff, busy_in;
   logic          done_ff, done_in;

   logic [W:0]    shifted;
   logic [W:0]    diff;
   logic          fits;

   always_comb begin
      shifted = {rem_ff, dvd_ff[W-1]};
      diff    = shifted - {1'b0, dsr_ff};
      fits    = shifted >= {1'b0, dsr_ff};

      rem_in  = rem_ff;
      dvd_in  = dvd_ff;
      dsr_in  = dsr_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;

      if (start) begin
         rem_in  = '0;
         dvd_in  = dividend;
         dsr_in  = divisor;
         cnt_in  = CW'(W);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         // shift the quotient bit in where the dividend bit leaves
         rem_in = fits ? diff[W-1:0] : shifted[W-1:0];
         dvd_in = {dvd_ff[W-2:0], fits};
         cnt_in = cnt_ff - CW'(1);
         if (cnt_ff == CW'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      rem_ff <= rem_in;
      dvd_ff <= dvd_in;
      dsr_ff <= dsr_in;
   end

   assign busy     = busy_ff;
   assign done     = done_ff;
   assign quotient = dvd_ff;

endmodule

`default_nettype wire

// File: sv/alr_shade.sv
`default_nettype none

// Scales the line color by a pixel weight, one channel per multiplier pass,
// and holds the finished pixel in the output register.
module alr_shade #(
   parameter int COORD_BITS = 10
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic [7:0]            color_red,
   input  wire logic [7:0]            color_green,
   input  wire logic [7:0]            color_blue,
   input  wire logic                  pix_valid,
   output logic                       pix_ready,
   input  wire logic [COORD_BITS-1:0] pix_x,
   input  wire logic [COORD_BITS-1:0] pix_y,
   input  wire logic [7:0]            pix_weight,
   input  wire alr_pkg::alr_flags_type pix_flags,
   output logic                       out_valid,
   input  wire logic                  out_ready,
   output logic [COORD_BITS-1:0]      out_x,
   output logic [COORD_BITS-1:0]      out_y,
   output logic [7:0]                 out_red,
   output logic [7:0]                 out_green,
   output logic [7:0]                 out_blue,
   output alr_pkg::alr_flags_type     out_flags
);

   logic                   busy_ff, busy_in;
   logic [1:0]             phase_ff, phase_in;
   logic [COORD_BITS-1:0]  x_ff, x_in;
   logic [COORD_BITS-1:0]  y_ff, y_in;
   logic [7:0]             w_ff, w_in;
   alr_pkg::alr_flags_type flags_ff, flags_in;
   logic [15:0]            prod_ff, prod_in;
   logic [7:0]             red_ff, red_in;
   logic [7:0]             green_ff, green_in;

   logic                   ovalid_ff, ovalid_in;
   logic [COORD_BITS-1:0]  ox_ff, ox_in;
   logic [COORD_BITS-1:0]  oy_ff, oy_in;
   logic [7:0]             ored_ff, ored_in;
   logic [7:0]             ogreen_ff, ogreen_in;
   logic [7:0]             oblue_ff, oblue_in;
   alr_pkg::alr_flags_type oflags_ff, oflags_in;

   logic [7:0]             color_sel;
   logic [15:0]            prod_next;
   logic [7:0]             scaled;
   logic                   out_free;

   always_comb begin
      case (phase_ff)
         2'd0:    color_sel = color_red;
         2'd1:    color_sel = color_green;
         default: color_sel = color_blue;
      endcase
      prod_next = 16'(w_ff) * 16'(color_sel);
      scaled    = alr_pkg::scale200(prod_ff);
   end

   assign out_free = !ovalid_ff || out_ready;

   always_comb begin
      busy_in   = busy_ff;
      phase_in  = phase_ff;
      x_in      = x_ff;
      y_in      = y_ff;
      w_in      = w_ff;
      flags_in  = flags_ff;
      prod_in   = prod_ff;
      red_in    = red_ff;
      green_in  = green_ff;
      ovalid_in = ovalid_ff && !out_ready;
      ox_in     = ox_ff;
      oy_in     = oy_ff;
      ored_in   = ored_ff;
      ogreen_in = ogreen_ff;
      oblue_in  = oblue_ff;
      oflags_in = oflags_ff;

      if (!busy_ff) begin
         if (pix_valid) begin
            busy_in  = 1'b1;
            phase_in = 2'd0;
            x_in     = pix_x;
            y_in     = pix_y;
            w_in     = pix_weight;
            flags_in = pix_flags;
         end
      end else begin
         case (phase_ff)
            2'd0: begin
               prod_in  = prod_next;
               phase_in = 2'd1;
            end
            2'd1: begin
               red_in   = scaled;
               prod_in  = prod_next;
               phase_in = 2'd2;
            end
            2'd2: begin
               green_in = scaled;
               prod_in  = prod_next;
               phase_in = 2'd3;
            end
            default: begin
               // hold the last product until the output register frees up
               if (out_free) begin
                  ovalid_in = 1'b1;
                  ox_in     = x_ff;
                  oy_in     = y_ff;
                  ored_in   = red_ff;
                  ogreen_in = green_ff;
                  oblue_in  = scaled;
                  oflags_in = flags_ff;
                  busy_in   = 1'b0;
               end
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff   <= 1'b0;
         phase_ff  <= 2'd0;
         ovalid_ff <= 1'b0;
      end else begin
         busy_ff   <= busy_in;
         phase_ff  <= phase_in;
         ovalid_ff <= ovalid_in;
      end
      x_ff      <= x_in;
      y_ff      <= y_in;
      w_ff      <= w_in;
      flags_ff  <= flags_in;
      prod_ff   <= prod_in;
      red_ff    <= red_in;
      green_ff  <= green_in;
      ox_ff     <= ox_in;
      oy_ff     <= oy_in;
      ored_ff   <= ored_in;
      ogreen_ff <= ogreen_in;
      oblue_ff  <= oblue_in;
      oflags_ff <= oflags_in;
   end

   assign pix_ready = !busy_ff;
   assign out_valid = ovalid_ff;
   assign out_x     = ox_ff;
   assign out_y     = oy_ff;
   assign out_red   = ored_ff;
   assign out_green = ogreen_ff;
   assign out_blue  = oblue_ff;
   assign out_flags = oflags_ff;

endmodule

`default_nettype wire

// File: sv/antialiased_line_rasterizer_unit.sv
`default_nettype none

// Channel  Direction  Transfer when          Contents
// req      in         req_tvalid&req_tready  command, two endpoints
// rsp      out        rsp_tvalid&rsp_tready  one shaded pixel
// csr      in         csr_we                 color register write
//
// A load runs the bit-serial divider, DW = max(COORD_BITS+8, 16) bits: it forms the slope of
// a shallow line, and slope and reciprocal for a steep one; a vertical line skips it. The
// load then sends its start pixel, and a step 1 to 3 pixels, once the shading unit is free:
// one shared 8x8 multiplier scales the three color channels in turn. A step with no line is
// dropped. Reset is synchronous and leaves no line loaded with full white color. A stalled
// rsp holds the shading unit, which in turn holds the sequencer; req_tready is high only
// between items.
module antialiased_line_rasterizer_unit #(
   parameter int COORD_BITS = 10
) (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire logic                      req_tvalid,
   output logic                           req_tready,
   // x_start, y_start, x_end, y_end
   input  wire logic [((4*COORD_BITS+7)/8)*8-1:0] req_tdata,
   // command
   input  wire logic                      req_tuser,
   output logic                           rsp_tvalid,
   input  wire logic                      rsp_tready,
   // pixel_x, pixel_y, red, green, blue
   output logic [((2*COORD_BITS+31)/8)*8-1:0] rsp_tdata,
   output logic                           rsp_tlast,
   // line_done
   output logic                           rsp_tuser,
   input  wire logic                      csr_we,
   input  wire logic [alr_pkg::CSR_IDX_BITS-1:0] csr_index,
   input  wire logic [7:0]                csr_wdata
);

   localparam int C      = COORD_BITS;
   localparam int DW     = (C + 8 > 16) ? C + 8 : 16;
   localparam int RSP_W  = ((2*C+31)/8)*8;

   localparam logic [3:0] S_IDLE  = 4'd0;
   localparam logic [3:0] S_DIV1  = 4'd1;
   localparam logic [3:0] S_WAIT1 = 4'd2;
   localparam logic [3:0] S_DIV2  = 4'd3;
   localparam logic [3:0] S_WAIT2 = 4'd4;
   localparam logic [3:0] S_START = 4'd5;
   localparam logic [3:0] S_MAIN  = 4'd6;
   localparam logic [3:0] S_NB    = 4'd7;
   localparam logic [3:0] S_END   = 4'd8;
   localparam logic [3:0] S_UPD   = 4'd9;

   logic [3:0]   state_ff, state_in;
   logic [7:0]   red_ff, red_in;
   logic [7:0]   green_ff, green_in;
   logic [7:0]   blue_ff, blue_in;
   logic [C-1:0] major_pos_ff, major_pos_in;
   logic [C-1:0] minor_pos_ff, minor_pos_in;
   logic [C-1:0] major_stop_ff, major_stop_in;
   logic [7:0]   error_acc_ff, error_acc_in;
   logic [7:0]   error_step_ff, error_step_in;
   logic [1:0]   minor_dir_ff, minor_dir_in;
   logic         steep_ff, steep_in;
   logic         line_active_ff, line_active_in;
   logic [C-1:0] stop_x_ff, stop_x_in;
   logic [C-1:0] stop_y_ff, stop_y_in;
   logic [C-1:0] dx_ff, dx_in;
   logic [C-1:0] dy_ff, dy_in;

   // load decode
   logic [C-1:0] xs, ys, xe, ye;
   logic [C-1:0] dx, dy;
   logic         ld_steep, ld_swap;
   logic [C-1:0] ax, ay, bx, by;
   logic [C-1:0] ld_minor, ld_target;

   // column values
   logic         last;
   logic         has_nb;
   logic [C-1:0] nb;
   logic [C-1:0] px, py;
   logic [8:0]   err_sum;

   // divider
   logic          div_start;
   logic [DW-1:0] div_dividend, div_divisor;
   logic          div_busy, div_done;
   logic [DW-1:0] div_q;

   // shading unit request
   logic                   pix_valid, pix_ready;
   logic [C-1:0]           pix_x, pix_y;
   logic [7:0]             pix_weight;
   alr_pkg::alr_flags_type pix_flags;
   logic [C-1:0]           out_x, out_y;
   logic [7:0]             out_red, out_green, out_blue;
   alr_pkg::alr_flags_type out_flags;

   logic req_fire;

   assign req_tready = (state_ff == S_IDLE);
   assign req_fire   = req_tvalid && req_tready;

   always_comb begin
      xs = req_tdata[C-1:0];
      ys = req_tdata[2*C-1:C];
      xe = req_tdata[3*C-1:2*C];
      ye = req_tdata[4*C-1:3*C];
      dx = (xe > xs) ? xe - xs : xs - xe;
      dy = (ye > ys) ? ye - ys : ys - ye;
      // floor(200*dy/dx) >= 200 exactly when dy >= dx
      ld_steep = (dx == '0) || (dy >= dx);
      ld_swap  = ld_steep ? (ys > ye) : (xs > xe);
      ax = ld_swap ? xe : xs;
      ay = ld_swap ? ye : ys;
      bx = ld_swap ? xs : xe;
      by = ld_swap ? ys : ye;
      ld_minor  = ld_steep ? ax : ay;
      ld_target = ld_steep ? bx : by;
   end

   always_comb begin
      last   = (major_pos_ff == major_stop_ff);
      has_nb = error_acc_ff > alr_pkg::NEIGHBOR_MIN;
      case (minor_dir_ff)
         alr_pkg::DIR_UP:   nb = minor_pos_ff + C'(1);
         alr_pkg::DIR_DOWN: nb = minor_pos_ff - C'(1);
         default:           nb = minor_pos_ff;
      endcase
      px      = steep_ff ? minor_pos_ff : major_pos_ff;
      py      = steep_ff ? major_pos_ff : minor_pos_ff;
      err_sum = 9'(error_acc_ff) + 9'(error_step_ff);
   end

   always_comb begin
      div_start    = 1'b0;
      div_dividend = (DW'(dy_ff) << 7) + (DW'(dy_ff) << 6) + (DW'(dy_ff) << 3);
      div_divisor  = DW'(dx_ff);
      pix_valid    = 1'b0;
      pix_x        = px;
      pix_y        = py;
      pix_weight   = alr_pkg::WEIGHT_FULL;
      pix_flags    = '0;

      state_in       = state_ff;
      major_pos_in   = major_pos_ff;
      minor_pos_in   = minor_pos_ff;
      major_stop_in  = major_stop_ff;
      error_acc_in   = error_acc_ff;
      error_step_in  = error_step_ff;
      minor_dir_in   = minor_dir_ff;
      steep_in       = steep_ff;
      line_active_in = line_active_ff;
      stop_x_in      = stop_x_ff;
      stop_y_in      = stop_y_ff;
      dx_in          = dx_ff;
      dy_in          = dy_ff;

      red_in   = (csr_we && csr_index == alr_pkg::CSR_RED)   ? csr_wdata : red_ff;
      green_in = (csr_we && csr_index == alr_pkg::CSR_GREEN) ? csr_wdata : green_ff;
      blue_in  = (csr_we && csr_index == alr_pkg::CSR_BLUE)  ? csr_wdata : blue_ff;

      unique case (state_ff)
         S_IDLE: begin
            if (req_fire) begin
               if (!req_tuser) begin
                  steep_in       = ld_steep;
                  major_pos_in   = ld_steep ? ay : ax;
                  minor_pos_in   = ld_minor;
                  major_stop_in  = ld_steep ? by : bx;
                  minor_dir_in   = (ld_target > ld_minor) ? alr_pkg::DIR_UP :
                                   (ld_target < ld_minor) ? alr_pkg::DIR_DOWN :
                                                            alr_pkg::DIR_NONE;
                  stop_x_in      = bx;
                  stop_y_in      = by;
                  error_acc_in   = '0;
                  line_active_in = 1'b1;
                  dx_in          = dx;
                  dy_in          = dy;
                  if (dx == '0) begin
                     error_step_in = alr_pkg::WEIGHT_FULL;
                     state_in      = S_START;
                  end else begin
                     state_in = S_DIV1;
                  end
               end else if (line_active_ff) begin
                  state_in = S_MAIN;
               end
            end
         end
         S_DIV1: begin
            div_start = 1'b1;
            state_in  = S_WAIT1;
         end
         S_WAIT1: begin
            if (div_done) begin
               if (steep_ff) begin
                  state_in = S_DIV2;
               end else begin
                  error_step_in = div_q[7:0];
                  state_in      = S_START;
               end
            end
         end
         S_DIV2: begin
            div_start    = 1'b1;
            div_dividend = DW'(alr_pkg::STEEP_RECIP);
            div_divisor  = div_q;
            state_in     = S_WAIT2;
         end
         S_WAIT2: begin
            if (div_done) begin
               error_step_in = div_q[7:0];
               state_in      = S_START;
            end
         end
         S_START: begin
            pix_valid             = 1'b1;
            pix_flags.end_of_item = 1'b1;
            if (pix_ready) state_in = S_IDLE;
         end
         S_MAIN: begin
            pix_valid             = 1'b1;
            pix_weight            = alr_pkg::WEIGHT_FULL - error_acc_ff;
            pix_flags.end_of_item = !last && !has_nb;
            if (pix_ready) state_in = has_nb ? S_NB : (last ? S_END : S_UPD);
         end
         S_NB: begin
            pix_valid             = 1'b1;
            pix_x                 = steep_ff ? nb : major_pos_ff;
            pix_y                 = steep_ff ? major_pos_ff : nb;
            pix_weight            = error_acc_ff;
            pix_flags.end_of_item = !last;
            if (pix_ready) state_in = last ? S_END : S_UPD;
         end
         S_END: begin
            pix_valid             = 1'b1;
            pix_x                 = stop_x_ff;
            pix_y                 = stop_y_ff;
            pix_flags.end_of_item = 1'b1;
            pix_flags.line_done   = 1'b1;
            if (pix_ready) state_in = S_UPD;
         end
         S_UPD: begin
            // advance the error; carry into the minor axis at or past full weight
            if (err_sum >= 9'(alr_pkg::WEIGHT_FULL)) begin
               minor_pos_in = nb;
               error_acc_in = 8'(err_sum - 9'(alr_pkg::WEIGHT_FULL));
            end else begin
               error_acc_in = err_sum[7:0];
            end
            if (last) line_active_in = 1'b0;
            else major_pos_in = major_pos_ff + C'(1);
            state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= S_IDLE;
         red_ff         <= alr_pkg::COLOR_RESET;
         green_ff       <= alr_pkg::COLOR_RESET;
         blue_ff        <= alr_pkg::COLOR_RESET;
         major_pos_ff   <= '0;
         minor_pos_ff   <= '0;
         major_stop_ff  <= '0;
         error_acc_ff   <= '0;
         error_step_ff  <= '0;
         minor_dir_ff   <= alr_pkg::DIR_NONE;
         steep_ff       <= 1'b0;
         line_active_ff <= 1'b0;
         stop_x_ff      <= '0;
         stop_y_ff      <= '0;
      end else begin
         state_ff       <= state_in;
         red_ff         <= red_in;
         green_ff       <= green_in;
         blue_ff        <= blue_in;
         major_pos_ff   <= major_pos_in;
         minor_pos_ff   <= minor_pos_in;
         major_stop_ff  <= major_stop_in;
         error_acc_ff   <= error_acc_in;
         error_step_ff  <= error_step_in;
         minor_dir_ff   <= minor_dir_in;
         steep_ff       <= steep_in;
         line_active_ff <= line_active_in;
         stop_x_ff      <= stop_x_in;
         stop_y_ff      <= stop_y_in;
      end
      dx_ff <= dx_in;
      dy_ff <= dy_in;
   end

   alr_div #(
      .W (DW)
   ) u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (div_dividend),
      .divisor  (div_divisor),
      .busy     (div_busy),
      .done     (div_done),
      .quotient (div_q)
   );

   alr_shade #(
      .COORD_BITS (C)
   ) u_shade (
      .clock       (clock),
      .reset       (reset),
      .color_red   (red_ff),
      .color_green (green_ff),
      .color_blue  (blue_ff),
      .pix_valid   (pix_valid),
      .pix_ready   (pix_ready),
      .pix_x       (pix_x),
      .pix_y       (pix_y),
      .pix_weight  (pix_weight),
      .pix_flags   (pix_flags),
      .out_valid   (rsp_tvalid),
      .out_ready   (rsp_tready),
      .out_x       (out_x),
      .out_y       (out_y),
      .out_red     (out_red),
      .out_green   (out_green),
      .out_blue    (out_blue),
      .out_flags   (out_flags)
   );

   assign rsp_tdata = RSP_W'({out_blue, out_green, out_red, out_y, out_x});
   assign rsp_tlast = out_flags.end_of_item;
   assign rsp_tuser = out_flags.line_done;

   a_div_start_idle: assert property (@(posedge clock) disable iff (reset)
      div_start |-> !div_busy)
      else $error("divider restarted while busy");

   a_load_arms_line: assert property (@(posedge clock) disable iff (reset)
      (req_fire && !req_tuser) |=> line_active_ff)
      else $error("load did not arm the line");

   a_error_in_range: assert property (@(posedge clock) disable iff (reset)
      error_acc_ff < alr_pkg::WEIGHT_FULL)
      else $error("error accumulator out of range");

   a_done_ends_item: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tuser) |-> rsp_tlast)
      else $error("line end pixel not marked last");

endmodule

`default_nettype wire

// File: bench/alr_tb_pkg.sv
package alr_tb_pkg;

   // Command carried on req_tuser.
   typedef enum logic {
      CMD_LOAD = 1'b0,
      CMD_STEP = 1'b1
   } alr_cmd_type;

endpackage

// File: bench/alr_checker.sv
module alr_checker #(
   parameter int COORD_BITS = 10
) (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              req_tvalid,
   input  wire logic                              req_tready,
   // x_start, y_start, x_end, y_end
   input  wire logic [((4*COORD_BITS+7)/8)*8-1:0] req_tdata,
   // command
   input  wire logic                              req_tuser,
   input  wire logic                              rsp_tvalid,
   input  wire logic                              rsp_tready,
   // pixel_x, pixel_y, red, green, blue
   input  wire logic [((2*COORD_BITS+31)/8)*8-1:0] rsp_tdata,
   input  wire logic                              rsp_tlast,
   // line_done
   input  wire logic                              rsp_tuser,
   input  wire logic                              csr_we,
   input  wire logic [alr_pkg::CSR_IDX_BITS-1:0]  csr_index,
   input  wire logic [7:0]                        csr_wdata,
   output int                                     error_count,
   output int                                     pending_count
);

   localparam int CB = COORD_BITS;
   localparam int MAX_REPORTS = 100;

   typedef struct packed {
      logic [CB-1:0] px;
      logic [CB-1:0] py;
      logic [7:0]    red;
      logic [7:0]    green;
      logic [7:0]    blue;
      logic          last_of_item;
      logic          line_end;
   } pixel_type;

   pixel_type expected_pixels[$];

   // Shadow of the line generator.
   logic [7:0]    color_r, color_g, color_b;
   logic [CB-1:0] major_at, minor_at, major_last, end_x, end_y;
   logic [8:0]    err_acc;
   logic [7:0]    err_inc;
   logic [1:0]    minor_step;
   logic          steep, active;

   function automatic logic [7:0] shade(input int unsigned weight, input logic [7:0] level);
      int unsigned product;
      product = weight * 32'(level);
      return 8'(product / 32'(alr_pkg::WEIGHT_FULL));
   endfunction

   function automatic pixel_type make_pixel(input logic [CB-1:0] x, input logic [CB-1:0] y,
                                            input int unsigned weight, input logic eoi,
                                            input logic done);
      pixel_type p;
      p.px = x;
      p.py = y;
      p.red = shade(weight, color_r);
      p.green = shade(weight, color_g);
      p.blue = shade(weight, color_b);
      p.last_of_item = eoi;
      p.line_end = done;
      return p;
   endfunction

   task automatic report_mismatch(input string what, input int got, input int want);
      if (error_count < MAX_REPORTS) begin
         $display("%0t: mismatch on %s: got %0d, expected %0d", $time, what, got, want);
      end
      error_count = error_count + 1;
   endtask

   task automatic trace_item(input logic cmd, input logic [CB-1:0] xs, input logic [CB-1:0] ys,
                             input logic [CB-1:0] xe, input logic [CB-1:0] ye);
      logic [CB-1:0] x1, y1, x2, y2, t, nb, px, py, delta;
      int unsigned   dx, dy, slope, err, full;
      logic          last;
      pixel_type     column[3];
      int            n;
      full = 32'(alr_pkg::WEIGHT_FULL);
      x1 = xs;
      y1 = ys;
      x2 = xe;
      y2 = ye;
      n = 0;
      if (cmd == alr_tb_pkg::CMD_LOAD) begin
         dx = (x2 > x1) ? 32'(x2 - x1) : 32'(x1 - x2);
         dy = (y2 > y1) ? 32'(y2 - y1) : 32'(y1 - y2);
         // vertical or single point: treated as steep with full increment
         slope = full;
         if (dx != 0) slope = full * dy / dx;
         steep = (slope >= full);
         if (!steep) begin
            if (x1 > x2) begin
               t = x1; x1 = x2; x2 = t;
               t = y1; y1 = y2; y2 = t;
            end
            major_at = x1;
            minor_at = y1;
            major_last = x2;
            minor_step = (y2 > y1) ? alr_pkg::DIR_UP :
                         ((y2 < y1) ? alr_pkg::DIR_DOWN : alr_pkg::DIR_NONE);
            err_inc = 8'(slope);
         end else begin
            if (y1 > y2) begin
               t = x1; x1 = x2; x2 = t;
               t = y1; y1 = y2; y2 = t;
            end
            major_at = y1;
            minor_at = x1;
            major_last = y2;
            minor_step = (x2 > x1) ? alr_pkg::DIR_UP :
                         ((x2 < x1) ? alr_pkg::DIR_DOWN : alr_pkg::DIR_NONE);
            err_inc = 8'(32'(alr_pkg::STEEP_RECIP) / slope);
         end
         end_x = x2;
         end_y = y2;
         err_acc = '0;
         active = 1'b1;
         expected_pixels.push_back(make_pixel(x1, y1, full, 1'b1, 1'b0));
      end else if (active) begin
         err = 32'(err_acc);
         last = (major_at == major_last);
         case (minor_step)
            alr_pkg::DIR_UP:   delta = CB'(1);
            alr_pkg::DIR_DOWN: delta = '1;
            default:           delta = '0;
         endcase
         // neighbor wraps around the coordinate range
         nb = minor_at + delta;
         px = steep ? minor_at : major_at;
         py = steep ? major_at : minor_at;
         column[0] = make_pixel(px, py, full - err, 1'b0, 1'b0);
         n = 1;
         if (err > 32'(alr_pkg::NEIGHBOR_MIN)) begin
            // steep lines put the neighbor on x
            if (steep) column[1] = make_pixel(nb, major_at, err, 1'b0, 1'b0);
            else column[1] = make_pixel(major_at, nb, err, 1'b0, 1'b0);
            n = 2;
         end
         err = err + 32'(err_inc);
         if (err >= full) begin
            minor_at = nb;
            err = err - full;
         end
         err_acc = 9'(err);
         if (last) begin
            column[n] = make_pixel(end_x, end_y, full, 1'b1, 1'b1);
            n = n + 1;
            active = 1'b0;
         end else begin
            major_at = major_at + CB'(1);
            column[n-1].last_of_item = 1'b1;
         end
         for (int i = 0; i < n; i++) expected_pixels.push_back(column[i]);
      end
   endtask

   task automatic check_pixel();
      pixel_type got, want;
      got.px = rsp_tdata[CB-1:0];
      got.py = rsp_tdata[2*CB-1:CB];
      got.red = rsp_tdata[2*CB+7:2*CB];
      got.green = rsp_tdata[2*CB+15:2*CB+8];
      got.blue = rsp_tdata[2*CB+23:2*CB+16];
      got.last_of_item = rsp_tlast;
      got.line_end = rsp_tuser;
      if (expected_pixels.size() == 0) begin
         report_mismatch("pixel with none expected, x", int'(got.px), -1);
      end else begin
         want = expected_pixels.pop_front();
         if (got.px !== want.px) report_mismatch("pixel_x", int'(got.px), int'(want.px));
         if (got.py !== want.py) report_mismatch("pixel_y", int'(got.py), int'(want.py));
         if (got.red !== want.red) report_mismatch("red", int'(got.red), int'(want.red));
         if (got.green !== want.green) begin
            report_mismatch("green", int'(got.green), int'(want.green));
         end
         if (got.blue !== want.blue) report_mismatch("blue", int'(got.blue), int'(want.blue));
         if (got.last_of_item !== want.last_of_item) begin
            report_mismatch("end_of_item", int'(got.last_of_item), int'(want.last_of_item));
         end
         if (got.line_end !== want.line_end) begin
            report_mismatch("line_done", int'(got.line_end), int'(want.line_end));
         end
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         error_count = 0;
         color_r = alr_pkg::COLOR_RESET;
         color_g = alr_pkg::COLOR_RESET;
         color_b = alr_pkg::COLOR_RESET;
         major_at = '0;
         minor_at = '0;
         major_last = '0;
         end_x = '0;
         end_y = '0;
         err_acc = '0;
         err_inc = '0;
         minor_step = alr_pkg::DIR_NONE;
         steep = 1'b0;
         active = 1'b0;
         expected_pixels.delete();
      end else begin
         if (rsp_tvalid && rsp_tready) check_pixel();
         if (csr_we) begin
            case (csr_index)
               alr_pkg::CSR_RED:   color_r = csr_wdata;
               alr_pkg::CSR_GREEN: color_g = csr_wdata;
               alr_pkg::CSR_BLUE:  color_b = csr_wdata;
               default:            ;
            endcase
         end
         if (req_tvalid && req_tready) begin
            trace_item(req_tuser, req_tdata[CB-1:0], req_tdata[2*CB-1:CB],
                       req_tdata[3*CB-1:2*CB], req_tdata[4*CB-1:3*CB]);
         end
      end
      pending_count = expected_pixels.size();
   end

endmodule

// File: bench/antialiased_line_rasterizer_unit_tb.sv
module antialiased_line_rasterizer_unit_tb;

   localparam int CB     = 10;
   localparam int REQ_W  = ((4*CB+7)/8)*8;
   localparam int RSP_W  = ((2*CB+31)/8)*8;
   localparam int CMAX   = (1 << CB) - 1;
   localparam int LIMIT  = 400000;
   localparam int SETTLE = 100;

   logic                             clock = 1'b0;
   logic                             reset;
   logic                             req_tvalid;
   logic                             req_tready;
   logic [REQ_W-1:0]                 req_tdata;
   logic                             req_tuser;
   logic                             rsp_tvalid;
   logic                             rsp_tready;
   logic [RSP_W-1:0]                 rsp_tdata;
   logic                             rsp_tlast;
   logic                             rsp_tuser;
   logic                             csr_we;
   logic [alr_pkg::CSR_IDX_BITS-1:0] csr_index;
   logic [7:0]                       csr_wdata;
   int                               error_count;
   int                               pixels_pending;
   int unsigned                      cycles = 0;
   int                               burst_left = 0;

   antialiased_line_rasterizer_unit #(.COORD_BITS(CB)) dut (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready),
      .req_tdata(req_tdata), .req_tuser(req_tuser),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready),
      .rsp_tdata(rsp_tdata), .rsp_tlast(rsp_tlast), .rsp_tuser(rsp_tuser),
      .csr_we(csr_we), .csr_index(csr_index), .csr_wdata(csr_wdata)
   );

   alr_checker #(.COORD_BITS(CB)) u_checker (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready),
      .req_tdata(req_tdata), .req_tuser(req_tuser),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready),
      .rsp_tdata(rsp_tdata), .rsp_tlast(rsp_tlast), .rsp_tuser(rsp_tuser),
      .csr_we(csr_we), .csr_index(csr_index), .csr_wdata(csr_wdata),
      .error_count(error_count), .pending_count(pixels_pending)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > LIMIT) begin
         $display("antialiased_line_rasterizer_unit_tb: done, errors");
         $finish;
      end
   end

   // Receiver: rotate through always-ready, random, sparse and long-stall stretches.
   always @(posedge clock) begin
      case (cycles[9:8])
         2'd0:    rsp_tready <= 1'b1;
         2'd1:    rsp_tready <= 1'($urandom_range(0, 1));
         2'd2:    rsp_tready <= (cycles[1:0] == 2'd0);
         default: rsp_tready <= (cycles % 9 == 0);
      endcase
   end

   function automatic logic [CB-1:0] rand_coord();
      return CB'($urandom);
   endfunction

   // Favor the edges of the coordinate range now and then.
   function automatic logic [CB-1:0] pick_coord();
      if ($urandom_range(0, 3) == 0) begin
         if ($urandom_range(0, 1) == 0) return CB'($urandom_range(0, 8));
         return CB'(CMAX - int'($urandom_range(0, 8)));
      end
      return rand_coord();
   endfunction

   function automatic logic [CB-1:0] offset(input logic [CB-1:0] c, input int d);
      int v;
      v = ($urandom_range(0, 1) == 0) ? int'(c) + d : int'(c) - d;
      if (v < 0) v = int'(c) + d;
      if (v > CMAX) v = int'(c) - d;
      return CB'(v);
   endfunction

   task automatic send_item(input alr_tb_pkg::alr_cmd_type cmd, input logic [CB-1:0] xs,
                            input logic [CB-1:0] ys, input logic [CB-1:0] xe,
                            input logic [CB-1:0] ye);
      int gap;
      if (burst_left == 0) begin
         gap = ($urandom_range(0, 3) == 0) ? 0 : int'($urandom_range(1, 8));
         if (gap != 0) begin
            req_tvalid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         burst_left = $urandom_range(1, 10);
      end
      req_tvalid <= 1'b1;
      req_tuser <= cmd;
      req_tdata <= REQ_W'({ye, xe, ys, xs});
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      burst_left = burst_left - 1;
   endtask

   // Step items carry random endpoint bits, which the block ignores.
   task automatic send_step();
      send_item(alr_tb_pkg::CMD_STEP, rand_coord(), rand_coord(), rand_coord(), rand_coord());
   endtask

   task automatic draw_line(input int x1, input int y1, input int x2, input int y2,
                            input int steps);
      send_item(alr_tb_pkg::CMD_LOAD, CB'(x1), CB'(y1), CB'(x2), CB'(y2));
      repeat (steps) send_step();
   endtask

   // Hold the sender until every pixel is out and the block has gone quiet.
   task automatic drain();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (pixels_pending != 0) @(posedge clock);
      repeat (SETTLE) @(posedge clock);
      burst_left = 0;
   endtask

   task automatic set_colors(input logic [7:0] r, input logic [7:0] g, input logic [7:0] b);
      csr_we <= 1'b1;
      csr_index <= alr_pkg::CSR_RED;
      csr_wdata <= r;
      @(posedge clock);
      csr_index <= alr_pkg::CSR_GREEN;
      csr_wdata <= g;
      @(posedge clock);
      csr_index <= alr_pkg::CSR_BLUE;
      csr_wdata <= b;
      @(posedge clock);
      csr_we <= 1'b0;
   endtask

   task automatic random_line(output int sent);
      logic [CB-1:0] x1, y1, x2, y2;
      int dx, dy, major, steps, kind;
      kind = $urandom_range(0, 19);
      if (kind == 0) begin
         // long line anywhere, dropped after a few columns
         x1 = rand_coord();
         y1 = rand_coord();
         x2 = rand_coord();
         y2 = rand_coord();
         steps = $urandom_range(0, 4);
      end else begin
         x1 = pick_coord();
         y1 = pick_coord();
         dx = $urandom_range(0, 12);
         dy = $urandom_range(0, 12);
         x2 = offset(x1, dx);
         y2 = offset(y1, dy);
         major = (dy >= dx) ? dy : dx;
         steps = major + 1;
         // cut short: the next load drops it
         if (kind < 4) steps = $urandom_range(0, major);
      end
      send_item(alr_tb_pkg::CMD_LOAD, x1, y1, x2, y2);
      repeat (steps) send_step();
      sent = 1 + steps;
      // steps past the end of a finished line
      if (kind >= 17) repeat ($urandom_range(1, 2)) send_step();
      if ($urandom_range(0, 9) == 0) drain();
   endtask

   task automatic random_phase(input int target);
      int total, sent;
      total = 0;
      while (total < target) begin
         random_line(sent);
         total = total + sent;
      end
      drain();
   endtask

   initial begin
      reset <= 1'b1;
      req_tvalid <= 1'b0;
      req_tdata <= '0;
      req_tuser <= alr_tb_pkg::CMD_LOAD;
      csr_we <= 1'b0;
      csr_index <= alr_pkg::CSR_RED;
      csr_wdata <= '0;
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      // step with no line loaded, all data bits high
      send_item(alr_tb_pkg::CMD_STEP, '1, '1, '1, '1);
      // shallow line given right to left, then one step past its end
      draw_line(5, 5, 2, 7, 5);
      // single point
      draw_line(CMAX, CMAX, CMAX, CMAX, 1);
      // full-range diagonal, dropped by the next load
      draw_line(0, CMAX, CMAX, 0, 2);
      // steep line at the right edge
      draw_line(CMAX - 2, 0, CMAX, 5, 6);
      // vertical line given bottom to top
      draw_line(0, 3, 0, 0, 4);
      // horizontal pair at the edge
      draw_line(CMAX - 1, 9, CMAX, 9, 2);
      drain();

      set_colors(8'd0, 8'd0, 8'd0);
      random_phase(12);
      set_colors(8'd255, 8'd255, 8'd255);
      random_phase(12);
      set_colors(8'd255, 8'd0, 8'd1);
      random_phase(12);
      set_colors(8'($urandom), 8'($urandom), 8'($urandom));
      random_phase(12);
      set_colors(8'($urandom), 8'($urandom), 8'($urandom));
      random_phase(12);

      if (error_count == 0 && pixels_pending == 0) begin
         $display("antialiased_line_rasterizer_unit_tb: done, clean");
      end else begin
         $display("antialiased_line_rasterizer_unit_tb: done, errors");
      end
      $finish;
   end

endmodule
